[rtl/static_list_symmetric_difference_macros.svh]
// Assertion macros for the list store RTL.
`ifndef STATIC_LIST_SYMMETRIC_DIFFERENCE_MACROS_SVH
`define STATIC_LIST_SYMMETRIC_DIFFERENCE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SLSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list store assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SLSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list store assertion failed");

`endif

[rtl/slsd_pkg.sv]
// Package with constants, codes and port bundles of the list store.
`timescale 1ns / 1ps

package slsd_pkg;

  // Store geometry.
  localparam int NODE_COUNT = 1024;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int VALUE_BITS = 32;

  // Operation codes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;
  localparam logic [1:0] OP_LOCATE = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_CLEARED  = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // Request to the link memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } link_req_t;

  // Request to the value memory.
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } val_req_t;

endpackage

[rtl/static_list_symmetric_difference.sv]
// Top level of the cursor-linked list store with symmetric-difference update.
//
// Input channel (in_valid / in_stall) carries one transaction: an operation
// (clear, append, toggle, locate) and a 32-bit value. Result channel
// (out_valid / out_stall) returns one status and node index per transaction.
// One transaction is worked on at a time; in_stall is high while it runs.
// The walk runs one node per cycle through the registered link and value
// memory read ports, so the list length sets the latency of a search.
// After reset the link memory is rebuilt by a clearing pass over the
// NODE_COUNT (1024) nodes during which in_stall stays high; it emits no result.
// The result sits in an output register; while the receiver stalls it holds
// steady, a new transaction may still be accepted, and its result waits
// until the register is taken.
`timescale 1ns / 1ps
`include "static_list_symmetric_difference_macros.svh"

module static_list_symmetric_difference (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_operation,
  input  logic signed [31:0]         in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [slsd_pkg::IDX_W-1:0] out_node_index
);

  localparam int IW = slsd_pkg::IDX_W;

  slsd_pkg::link_req_t                 lreq;
  slsd_pkg::val_req_t                  vreq;
  logic [slsd_pkg::IDX_W-1:0]          link_rdata;
  logic [slsd_pkg::VALUE_BITS-1:0]     val_rdata;
  logic                                out_miss;
  logic                                out_hit;

  // Sequencer.
  slsd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_node_index (out_node_index),
    .lreq           (lreq),
    .link_rdata     (link_rdata),
    .vreq           (vreq),
    .val_rdata      (val_rdata)
  );

  // Node link memory.
  slsd_ram #(
    .WIDTH (slsd_pkg::IDX_W),
    .DEPTH (slsd_pkg::NODE_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (lreq.we),
    .waddr (lreq.waddr),
    .wdata (lreq.wdata),
    .raddr (lreq.raddr),
    .rdata (link_rdata)
  );

  // Node value memory.
  slsd_ram #(
    .WIDTH (slsd_pkg::VALUE_BITS),
    .DEPTH (slsd_pkg::NODE_COUNT)
  ) u_val_ram (
    .clk   (clk),
    .we    (vreq.we),
    .waddr (vreq.waddr),
    .wdata (vreq.wdata),
    .raddr (vreq.raddr),
    .rdata (val_rdata)
  );

  // Result classes: a miss or a full store carries no node, the others do.
  assign out_miss = (out_status == slsd_pkg::ST_NOTFOUND) ||
                    (out_status == slsd_pkg::ST_FULL);
  assign out_hit  = (out_status == slsd_pkg::ST_APPENDED) ||
                    (out_status == slsd_pkg::ST_REMOVED) ||
                    (out_status == slsd_pkg::ST_FOUND);

  // Checks on the sequencer and the result codes.
  `SLSD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `SLSD_ASSERT_NOW(a_status_range, out_valid, out_status <= slsd_pkg::ST_FULL)
  `SLSD_ASSERT_NOW(a_no_node_on_miss, out_valid && out_miss, out_node_index == '0)
  `SLSD_ASSERT_NOW(a_node_on_hit, out_valid && out_hit, out_node_index > IW'(1))

endmodule

[rtl/slsd_ram.sv]
// Simple dual-port memory with one write port and one registered read port.
`timescale 1ns / 1ps

module slsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/slsd_ctrl.sv]
// Sequencer that walks, links and frees nodes and holds the result register.
`timescale 1ns / 1ps

module slsd_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_operation,
  input  logic signed [31:0]             in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [slsd_pkg::IDX_W-1:0]     out_node_index,
  output slsd_pkg::link_req_t            lreq,
  input  logic [slsd_pkg::IDX_W-1:0]     link_rdata,
  output slsd_pkg::val_req_t             vreq,
  input  logic [slsd_pkg::VALUE_BITS-1:0] val_rdata
);

  localparam int IW = slsd_pkg::IDX_W;
  localparam int VW = slsd_pkg::VALUE_BITS;
  localparam logic [IW-1:0] IDX_ZERO = '0;
  localparam logic [IW-1:0] IDX_ONE  = IW'(1);
  localparam logic [IW-1:0] IDX_TWO  = IW'(2);
  localparam logic [IW-1:0] IDX_LAST = IW'(slsd_pkg::NODE_COUNT - 1);

  // Sequencer states.
  localparam logic [3:0] S_SWEEP = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRCH0 = 4'd2;
  localparam logic [3:0] S_SRCH1 = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_RM0   = 4'd5;
  localparam logic [3:0] S_RM1   = 4'd6;
  localparam logic [3:0] S_RM2   = 4'd7;
  localparam logic [3:0] S_AL0   = 4'd8;
  localparam logic [3:0] S_AL1   = 4'd9;
  localparam logic [3:0] S_AL2   = 4'd10;
  localparam logic [3:0] S_AL3   = 4'd11;
  localparam logic [3:0] S_AL4   = 4'd12;
  localparam logic [3:0] S_RES   = 4'd13;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] link_r, link_nxt;
  logic [IW-1:0] steps_r, steps_nxt;
  logic [IW-1:0] sweep_r, sweep_nxt;
  logic          report_r, report_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [IW-1:0] res_node_r, res_node_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [IW-1:0] out_node_r, out_node_nxt;

  // Next-state and memory request logic.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    link_nxt       = link_r;
    steps_nxt      = steps_r;
    sweep_nxt      = sweep_r;
    report_nxt     = report_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    res_status_nxt = res_status_r;
    res_node_nxt   = res_node_r;
    out_status_nxt = out_status_r;
    out_node_nxt   = out_node_r;
    out_valid_nxt  = out_valid_r && out_stall;
    lreq           = '0;
    vreq           = '0;

    case (state_r)
      // Rebuild the whole chain: node 1 is the head, nodes 2 and up are free.
      S_SWEEP: begin
        lreq.we    = 1'b1;
        lreq.waddr = sweep_r;
        if (sweep_r == IDX_ZERO) begin
          lreq.wdata = IDX_TWO;
        end else if (sweep_r == IDX_ONE || sweep_r == IDX_LAST) begin
          lreq.wdata = IDX_ZERO;
        end else begin
          lreq.wdata = sweep_r + IDX_ONE;
        end
        sweep_nxt = sweep_r + IDX_ONE;
        if (sweep_r == IDX_LAST) begin
          head_nxt = IDX_ONE;
          tail_nxt = IDX_ONE;
          if (report_r) begin
            res_status_nxt = slsd_pkg::ST_CLEARED;
            res_node_nxt   = IDX_ONE;
            state_nxt      = S_RES;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      // Take a new transaction.
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_operation;
          val_nxt = in_value[VW-1:0];
          case (in_operation)
            slsd_pkg::OP_CLEAR: begin
              sweep_nxt  = IDX_ZERO;
              report_nxt = 1'b1;
              state_nxt  = S_SWEEP;
            end
            slsd_pkg::OP_APPEND: state_nxt = S_AL0;
            default:             state_nxt = S_SRCH0;
          endcase
        end
      end

      // Read the head's link to find the first data node.
      S_SRCH0: begin
        lreq.raddr = head_r;
        prev_nxt   = head_r;
        steps_nxt  = IDX_ZERO;
        state_nxt  = S_SRCH1;
      end

      S_SRCH1: begin
        cur_nxt    = link_rdata;
        lreq.raddr = link_rdata;
        vreq.raddr = link_rdata;
        if (link_rdata == IDX_ZERO) begin
          if (op_r == slsd_pkg::OP_LOCATE) begin
            res_status_nxt = slsd_pkg::ST_NOTFOUND;
            res_node_nxt   = IDX_ZERO;
            state_nxt      = S_RES;
          end else begin
            state_nxt = S_AL0;
          end
        end else begin
          state_nxt = S_CMP;
        end
      end

      // One node per cycle: compare its value and follow its link.
      S_CMP: begin
        if (val_rdata == val_r) begin
          link_nxt = link_rdata;
          if (op_r == slsd_pkg::OP_LOCATE) begin
            res_status_nxt = slsd_pkg::ST_FOUND;
            res_node_nxt   = cur_r;
            state_nxt      = S_RES;
          end else begin
            state_nxt = S_RM0;
          end
        end else if (link_rdata == IDX_ZERO || steps_r == IDX_LAST) begin
          if (op_r == slsd_pkg::OP_LOCATE) begin
            res_status_nxt = slsd_pkg::ST_NOTFOUND;
            res_node_nxt   = IDX_ZERO;
            state_nxt      = S_RES;
          end else begin
            state_nxt = S_AL0;
          end
        end else begin
          prev_nxt   = cur_r;
          cur_nxt    = link_rdata;
          steps_nxt  = steps_r + IDX_ONE;
          lreq.raddr = link_rdata;
          vreq.raddr = link_rdata;
        end
      end

      // Unlink the match and read the free chain head.
      S_RM0: begin
        lreq.we    = 1'b1;
        lreq.waddr = prev_r;
        lreq.wdata = link_r;
        lreq.raddr = IDX_ZERO;
        state_nxt  = S_RM1;
      end

      // The freed node points at the old free chain head.
      S_RM1: begin
        lreq.we    = 1'b1;
        lreq.waddr = cur_r;
        lreq.wdata = link_rdata;
        state_nxt  = S_RM2;
      end

      // The freed node becomes the free chain head.
      S_RM2: begin
        lreq.we    = 1'b1;
        lreq.waddr = IDX_ZERO;
        lreq.wdata = cur_r;
        if (tail_r == cur_r) begin
          tail_nxt = prev_r;
        end
        res_status_nxt = slsd_pkg::ST_REMOVED;
        res_node_nxt   = cur_r;
        state_nxt      = S_RES;
      end

      // Allocation: read the free chain head.
      S_AL0: begin
        lreq.raddr = IDX_ZERO;
        state_nxt  = S_AL1;
      end

      S_AL1: begin
        cur_nxt    = link_rdata;
        lreq.raddr = link_rdata;
        if (link_rdata == IDX_ZERO) begin
          res_status_nxt = slsd_pkg::ST_FULL;
          res_node_nxt   = IDX_ZERO;
          state_nxt      = S_RES;
        end else begin
          state_nxt = S_AL2;
        end
      end

      // Pop the node off the free chain and store the value.
      S_AL2: begin
        lreq.we    = 1'b1;
        lreq.waddr = IDX_ZERO;
        lreq.wdata = link_rdata;
        vreq.we    = 1'b1;
        vreq.waddr = cur_r;
        vreq.wdata = val_r;
        state_nxt  = S_AL3;
      end

      // The new node ends the list.
      S_AL3: begin
        lreq.we    = 1'b1;
        lreq.waddr = cur_r;
        lreq.wdata = IDX_ZERO;
        state_nxt  = S_AL4;
      end

      // Hook it behind the old tail.
      S_AL4: begin
        lreq.we        = 1'b1;
        lreq.waddr     = tail_r;
        lreq.wdata     = cur_r;
        tail_nxt       = cur_r;
        res_status_nxt = slsd_pkg::ST_APPENDED;
        res_node_nxt   = cur_r;
        state_nxt      = S_RES;
      end

      // Hand the result to the output register once it is free.
      S_RES: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_node_nxt   = res_node_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      report_r    <= 1'b0;
      head_r      <= IDX_ONE;
      tail_r      <= IDX_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      report_r    <= report_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    link_r       <= link_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_node_r   <= res_node_nxt;
    out_status_r <= out_status_nxt;
    out_node_r   <= out_node_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_node_r;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the cursor-linked list store with symmetric-difference update.
`timescale 1ns / 1ps

module testbench;

  typedef logic [slsd_pkg::IDX_W-1:0] idx_t;

  // One result transaction as predicted for the output channel.
  typedef struct packed {
    logic [2:0] status;
    idx_t       node;
  } reply_t;

  localparam int QUIET_LIMIT = 20000;
  localparam int POOL_SIZE   = 12;
  localparam int ROUNDS      = 12;
  localparam int ROUND_ITEMS = 46;

  // Mirror of the node store that predicts each reply and checks it on arrival.
  class symdiff_scoreboard;
    logic [slsd_pkg::VALUE_BITS-1:0] node_val [slsd_pkg::NODE_COUNT];
    idx_t                            node_next [slsd_pkg::NODE_COUNT];
    idx_t                            head_idx;
    idx_t                            tail_idx;
    reply_t                          replies [$];
    int                              errors;

    function new();
      foreach (node_val[i]) node_val[i] = '0;
      errors = 0;
      rebuild_store();
    endfunction

    // Take the first node off the free chain, or 0 when it is empty.
    function idx_t pop_free();
      idx_t i;
      i = node_next[0];
      if (i != 0) node_next[0] = node_next[i];
      return i;
    endfunction

    // Chain every node as free and allocate the head of an empty list.
    function void rebuild_store();
      for (int i = 0; i < slsd_pkg::NODE_COUNT - 1; i++) node_next[i] = idx_t'(i + 1);
      node_next[slsd_pkg::NODE_COUNT-1] = '0;
      head_idx = pop_free();
      node_next[head_idx] = '0;
      tail_idx = head_idx;
    endfunction

    // Add a value behind the tail; returns 0 when the store is full.
    function idx_t link_at_tail(logic [slsd_pkg::VALUE_BITS-1:0] v);
      idx_t i;
      i = pop_free();
      if (i == 0) return '0;
      node_val[i] = v;
      node_next[i] = '0;
      node_next[tail_idx] = i;
      tail_idx = i;
      return i;
    endfunction

    // Apply one accepted input transaction and queue the reply it causes.
    function void note_transaction(logic [1:0] op, logic [31:0] value);
      logic [slsd_pkg::VALUE_BITS-1:0] v;
      reply_t r;
      idx_t prev;
      idx_t cur;
      int steps;
      v = value[slsd_pkg::VALUE_BITS-1:0];
      case (op)
        slsd_pkg::OP_CLEAR: begin
          rebuild_store();
          r.status = slsd_pkg::ST_CLEARED;
          r.node = head_idx;
        end
        slsd_pkg::OP_APPEND: begin
          r.node = link_at_tail(v);
          r.status = (r.node != 0) ? slsd_pkg::ST_APPENDED : slsd_pkg::ST_FULL;
        end
        default: begin
          // Walk the data list from the head, bounded by the store size.
          prev = head_idx;
          cur = node_next[prev];
          steps = 0;
          while (cur != 0 && node_val[cur] != v && steps < slsd_pkg::NODE_COUNT) begin
            prev = cur;
            cur = node_next[cur];
            steps++;
          end
          if (steps >= slsd_pkg::NODE_COUNT) cur = '0;
          if (op == slsd_pkg::OP_LOCATE) begin
            r.status = (cur != 0) ? slsd_pkg::ST_FOUND : slsd_pkg::ST_NOTFOUND;
            r.node = cur;
          end else if (cur == 0) begin
            r.node = link_at_tail(v);
            r.status = (r.node != 0) ? slsd_pkg::ST_APPENDED : slsd_pkg::ST_FULL;
          end else begin
            // Unlink the match, return it to the free chain, pull the tail back.
            node_next[prev] = node_next[cur];
            node_next[cur] = node_next[0];
            node_next[0] = cur;
            if (tail_idx == cur) tail_idx = prev;
            r.status = slsd_pkg::ST_REMOVED;
            r.node = cur;
          end
        end
      endcase
      replies.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // Compare an accepted result transaction with the oldest prediction.
    function void check_result(logic [2:0] status, idx_t node);
      reply_t want;
      if (replies.size() == 0) begin
        report($sformatf("status %0d node %0d arrived with nothing pending", status, node));
        return;
      end
      want = replies.pop_front();
      if (want.status !== status)
        report($sformatf("status expected %0d, got %0d", want.status, status));
      if (want.node !== node)
        report($sformatf("node_index expected %0d, got %0d", want.node, node));
    endfunction

    function int outstanding();
      return replies.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = slsd_pkg::OP_CLEAR;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  idx_t        out_node_index;

  symdiff_scoreboard tracker;
  bit                calm = 1'b0;
  int                hold_left = 0;
  int unsigned       quiet_cycles = 0;

  static_list_symmetric_difference uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_node_index (out_node_index)
  );

  always #2 clk = ~clk;

  // Offer one input transaction after a random gap and hold it until accepted.
  task automatic issue_transaction(logic [1:0] op, logic [31:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_transaction(op, value);
  endtask

  // Stop sending until every predicted reply has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // Receiver: after each accepted result, stall for a random number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      hold_left = calm ? 0 : $urandom_range(0, 9);
      out_stall <= (hold_left != 0);
    end else if (out_stall) begin
      hold_left = hold_left - 1;
      out_stall <= (hold_left != 0);
    end
  end

  // Check every result transaction the receiver takes.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(out_status, out_node_index);
    end
  end

  // Count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [31:0] value_pool [POOL_SIZE];
    logic [31:0] val;
    int          pick;
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, value extremes, removals in the middle and at the tail.
    issue_transaction(slsd_pkg::OP_LOCATE, 32'h0000_0000);
    issue_transaction(slsd_pkg::OP_TOGGLE, 32'h0000_0005);
    issue_transaction(slsd_pkg::OP_APPEND, 32'h7FFF_FFFF);
    issue_transaction(slsd_pkg::OP_APPEND, 32'h8000_0000);
    issue_transaction(slsd_pkg::OP_APPEND, 32'h0000_0000);
    issue_transaction(slsd_pkg::OP_APPEND, 32'hFFFF_FFFF);
    issue_transaction(slsd_pkg::OP_LOCATE, 32'h8000_0000);
    issue_transaction(slsd_pkg::OP_LOCATE, 32'h0000_0001);
    issue_transaction(slsd_pkg::OP_TOGGLE, 32'h8000_0000);
    issue_transaction(slsd_pkg::OP_TOGGLE, 32'hFFFF_FFFF);
    issue_transaction(slsd_pkg::OP_APPEND, 32'h1234_5678);
    issue_transaction(slsd_pkg::OP_LOCATE, 32'h1234_5678);
    issue_transaction(slsd_pkg::OP_TOGGLE, 32'h0000_0005);
    issue_transaction(slsd_pkg::OP_TOGGLE, 32'h8000_0000);
    issue_transaction(slsd_pkg::OP_LOCATE, 32'hFFFF_FFFF);
    wait_for_results();
    issue_transaction(slsd_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    issue_transaction(slsd_pkg::OP_LOCATE, 32'h7FFF_FFFF);
    issue_transaction(slsd_pkg::OP_APPEND, 32'h5555_5555);
    issue_transaction(slsd_pkg::OP_APPEND, 32'hAAAA_AAAA);
    issue_transaction(slsd_pkg::OP_TOGGLE, 32'hAAAA_AAAA);
    issue_transaction(slsd_pkg::OP_TOGGLE, 32'h5555_5555);
    issue_transaction(slsd_pkg::OP_APPEND, 32'h0000_0001);
    issue_transaction(slsd_pkg::OP_LOCATE, 32'h0000_0001);

    // Random rounds: values mostly from a small pool so toggles and locates hit.
    value_pool[0] = 32'h7FFF_FFFF;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      if (rnd % 4 == 3) wait_for_results();
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 4; k < POOL_SIZE; k++) value_pool[k] = $urandom;
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        val = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          issue_transaction(slsd_pkg::OP_CLEAR, val);
        end else if (pick < 38) begin
          issue_transaction(slsd_pkg::OP_APPEND, val);
        end else if (pick < 73) begin
          issue_transaction(slsd_pkg::OP_TOGGLE, val);
        end else begin
          issue_transaction(slsd_pkg::OP_LOCATE, val);
        end
      end
    end

    // Drain, then give stray results a chance to show up.
    wait_for_results();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/slsd_pkg.sv
rtl/slsd_ram.sv
rtl/slsd_ctrl.sv
rtl/static_list_symmetric_difference.sv
dv/testbench.sv
